// File: rtl/iee_pkg.sv
// Token, operator and error codes and sequencer types of the expression evaluator.
package iee_pkg;

    localparam logic [2:0] TOK_NUMBER   = 3'd0;
    localparam logic [2:0] TOK_OPERATOR = 3'd1;
    localparam logic [2:0] TOK_LPAREN   = 3'd2;
    localparam logic [2:0] TOK_RPAREN   = 3'd3;
    localparam logic [2:0] TOK_END      = 3'd4;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_PAREN = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
    localparam logic [2:0] ERR_UNMATCHED  = 3'd2;
    localparam logic [2:0] ERR_DIVZERO    = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd4;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd5;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_POP_RD  = 10'b00_0000_0010,
        S_POP_CHK = 10'b00_0000_0100,
        S_AP_B    = 10'b00_0000_1000,
        S_AP_C    = 10'b00_0001_0000,
        S_DIV     = 10'b00_0010_0000,
        S_DFIX    = 10'b00_0100_0000,
        S_WB      = 10'b00_1000_0000,
        S_RES     = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        M_OPER = 2'd0,
        M_RPAR = 2'd1,
        M_END  = 2'd2
    } t_mode;

    function automatic logic stacks_above(input logic [2:0] top, input logic [1:0] incoming);
        logic hi;
        hi = ({1'b0, incoming} == OP_MUL) || ({1'b0, incoming} == OP_DIV);
        return (top == OP_PAREN) || (((top == OP_ADD) || (top == OP_SUB)) && hi);
    endfunction

endpackage

// File: rtl/iee_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/infix_expression_evaluator.sv
// Top level of the shunting-yard infix expression evaluator.
// Each accepted word is one token; a result word (value and error code) appears only
// after the end token, and the block then clears itself. Numbers, left parentheses and
// tokens that find an error are handled in S_IDLE alone. An operator, right parenthesis
// or end token also pops operators from the stack: each pop passes S_POP_RD and
// S_POP_CHK, and each applied operator S_AP_B, S_AP_C and S_WB, with S_DIV and S_DFIX
// for divide, since one shared restoring divider produces one quotient bit per cycle.
// The end token then reads the result in S_RES and holds it in S_OUT until taken. Both
// stacks live in RAMs with registered reads; o_ready is low while a token is worked on.
module infix_expression_evaluator #(
    parameter int OPERATOR_DEPTH = 64,
    parameter int VALUE_DEPTH    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [30:0] i_number_value,
    input  logic [1:0]  i_sign_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_result_value,
    output logic [2:0]  o_error_code
);
    import iee_pkg::*;

    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
    localparam int OAW = $clog2(OPERATOR_DEPTH);
    localparam int PW  = $clog2(OPERATOR_DEPTH + 2);
    localparam int VCW = $clog2(VALUE_DEPTH + 1);
    localparam int VAW = $clog2(VALUE_DEPTH);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [OCW-1:0] r_otop, n_otop;
    logic [VCW-1:0] r_vtop, n_vtop;
    logic [PW-1:0]  r_open, n_open;
    logic           r_expect, n_expect;
    logic [2:0]     r_err, n_err;
    logic [1:0]     r_sign, n_sign;
    logic [2:0]     r_apop, n_apop;
    logic [31:0]    r_rhs, n_rhs;
    logic [31:0]    r_res, n_res;
    logic [31:0]    r_dq, n_dq;
    logic [31:0]    r_rem, n_rem;
    logic [31:0]    r_dvs, n_dvs;
    logic           r_dneg, n_dneg;
    logic [4:0]     r_cnt, n_cnt;

    logic           o_we, v_we;
    logic [OAW-1:0] o_waddr, o_raddr;
    logic [2:0]     o_wdata, o_rdata;
    logic [VAW-1:0] v_waddr, v_raddr;
    logic [31:0]    v_wdata, v_rdata;

    logic [32:0]    div_sh;
    logic           div_ge;
    logic [31:0]    lhs_abs, rhs_abs;

    iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_oram (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    iee_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_vram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    assign o_raddr = OAW'(r_otop - OCW'(1));
    assign v_raddr = (r_state == S_AP_B) ? VAW'(r_vtop - VCW'(2)) : VAW'(r_vtop - VCW'(1));

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_result_value = (r_err == ERR_NONE) ? r_res : 32'sd0;
    assign o_error_code   = r_err;

    assign div_sh  = {r_rem, r_dq[31]};
    assign div_ge  = div_sh >= {1'b0, r_dvs};
    assign lhs_abs = v_rdata[31] ? (32'd0 - v_rdata) : v_rdata;
    assign rhs_abs = r_rhs[31] ? (32'd0 - r_rhs) : r_rhs;

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_otop   = r_otop;
        n_vtop   = r_vtop;
        n_open   = r_open;
        n_expect = r_expect;
        n_err    = r_err;
        n_sign   = r_sign;
        n_apop   = r_apop;
        n_rhs    = r_rhs;
        n_res    = r_res;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_dneg   = r_dneg;
        n_cnt    = r_cnt;
        o_we     = 1'b0;
        o_waddr  = OAW'(r_otop);
        o_wdata  = {1'b0, r_sign};
        v_we     = 1'b0;
        v_waddr  = VAW'(r_vtop);
        v_wdata  = {1'b0, i_number_value};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == TOK_END) begin
                        if (r_err != ERR_NONE) begin
                            n_state = S_OUT;
                        end else if (!r_expect) begin
                            n_err   = ERR_INCOMPLETE;
                            n_state = S_OUT;
                        end else begin
                            n_mode  = M_END;
                            n_state = S_POP_RD;
                        end
                    end else if (r_err == ERR_NONE) begin
                        if (!r_expect) begin
                            if (i_op == TOK_NUMBER) begin
                                n_expect = 1'b1;
                                if (r_vtop >= VCW'(VALUE_DEPTH)) begin
                                    n_err = ERR_OVERFLOW;
                                end else begin
                                    v_we   = 1'b1;
                                    n_vtop = r_vtop + VCW'(1);
                                end
                            end else if (i_op == TOK_LPAREN) begin
                                n_open = r_open + PW'(1);
                                if (r_otop >= OCW'(OPERATOR_DEPTH)) begin
                                    n_err = ERR_OVERFLOW;
                                end else begin
                                    o_we    = 1'b1;
                                    o_wdata = OP_PAREN;
                                    n_otop  = r_otop + OCW'(1);
                                end
                            end else begin
                                n_err = ERR_UNEXPECTED;
                            end
                        end else begin
                            if (i_op == TOK_RPAREN) begin
                                if (r_open == '0) begin
                                    n_err = ERR_UNMATCHED;
                                end else begin
                                    n_open  = r_open - PW'(1);
                                    n_mode  = M_RPAR;
                                    n_state = S_POP_RD;
                                end
                            end else if (i_op == TOK_OPERATOR) begin
                                n_sign   = i_sign_code;
                                n_expect = 1'b0;
                                n_mode   = M_OPER;
                                n_state  = S_POP_RD;
                            end else begin
                                n_err = ERR_UNEXPECTED;
                            end
                        end
                    end
                end
            end
            S_POP_RD: begin
                if (r_otop == '0) begin
                    if (r_mode == M_OPER) begin
                        o_we    = 1'b1;
                        n_otop  = r_otop + OCW'(1);
                        n_state = S_IDLE;
                    end else if (r_mode == M_RPAR) begin
                        n_state = S_IDLE;
                    end else if (r_vtop != '0) begin
                        n_state = S_RES;
                    end else begin
                        n_err   = ERR_INCOMPLETE;
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_POP_CHK;
                end
            end
            S_POP_CHK: begin
                n_apop = o_rdata;
                if (r_mode == M_OPER && stacks_above(o_rdata, r_sign)) begin
                    n_state = S_IDLE;
                    if (r_otop >= OCW'(OPERATOR_DEPTH)) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        o_we   = 1'b1;
                        n_otop = r_otop + OCW'(1);
                    end
                end else begin
                    n_otop = r_otop - OCW'(1);
                    if (o_rdata == OP_PAREN) begin
                        n_state = (r_mode == M_END) ? S_POP_RD : S_IDLE;
                    end else if (r_vtop < VCW'(2)) begin
                        n_err   = ERR_INCOMPLETE;
                        n_state = (r_mode == M_END) ? S_OUT : S_IDLE;
                    end else begin
                        n_state = S_AP_B;
                    end
                end
            end
            S_AP_B: begin
                n_rhs   = v_rdata;
                n_state = S_AP_C;
            end
            S_AP_C: begin
                n_state = S_WB;
                case (r_apop)
                    OP_ADD: n_res = v_rdata + r_rhs;
                    OP_SUB: n_res = v_rdata - r_rhs;
                    OP_MUL: n_res = v_rdata * r_rhs;
                    default: begin
                        if (r_rhs == 32'd0) begin
                            n_err   = ERR_DIVZERO;
                            n_state = (r_mode == M_END) ? S_OUT : S_IDLE;
                        end else begin
                            n_dq    = lhs_abs;
                            n_dvs   = rhs_abs;
                            n_rem   = 32'd0;
                            n_cnt   = 5'd0;
                            n_dneg  = v_rdata[31] ^ r_rhs[31];
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                n_rem = div_ge ? 32'(div_sh - {1'b0, r_dvs}) : div_sh[31:0];
                n_dq  = {r_dq[30:0], div_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_DFIX;
                end
            end
            S_DFIX: begin
                n_res   = r_dneg ? (32'd0 - r_dq) : r_dq;
                n_state = S_WB;
            end
            S_WB: begin
                v_we    = 1'b1;
                v_waddr = VAW'(r_vtop - VCW'(2));
                v_wdata = r_res;
                n_vtop  = r_vtop - VCW'(1);
                n_state = S_POP_RD;
            end
            S_RES: begin
                n_res   = v_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state  = S_IDLE;
                    n_otop   = '0;
                    n_vtop   = '0;
                    n_open   = '0;
                    n_expect = 1'b0;
                    n_err    = ERR_NONE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_OPER;
            r_otop   <= '0;
            r_vtop   <= '0;
            r_open   <= '0;
            r_expect <= 1'b0;
            r_err    <= ERR_NONE;
            r_cnt    <= 5'd0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_otop   <= n_otop;
            r_vtop   <= n_vtop;
            r_open   <= n_open;
            r_expect <= n_expect;
            r_err    <= n_err;
            r_cnt    <= n_cnt;
        end
        r_sign <= n_sign;
        r_apop <= n_apop;
        r_rhs  <= n_rhs;
        r_res  <= n_res;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_dneg <= n_dneg;
    end
endmodule
